@@ sv/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the message stream deframer
// Word layouts of both channels, result kinds, parser phases and defaults.
// ----------------------------------------------------------------------------
package msd_pkg;

  // default geometry
  localparam int MSD_ID_BYTES         = 2;
  localparam int MSD_LENGTH_BYTES     = 2;
  localparam int MSD_EXT_LENGTH_BYTES = 4;
  localparam int MSD_TABLE_DEPTH      = 1024;

  // longest body accepted when the limit is enforced
  localparam logic [31:0] BODY_LIMIT = 32'd65535;

  // table entry: {known, variable, length}
  localparam int ENTRY_W = 18;

  // input function codes
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_OVERSIZE = 3'd3,
    KIND_BADEXT   = 3'd4
  } msd_kind_e;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_EXT  = 2'd2,
    PH_BODY = 2'd3
  } msd_phase_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [9:0]  table_index;
    logic        entry_known;
    logic        entry_variable;
    logic [15:0] entry_length;
  } msd_in_t;

  typedef struct packed {
    msd_kind_e   kind;
    logic [15:0] message_id;
    logic [7:0]  body_byte;
    logic [31:0] message_length;
    logic        last;
  } msd_out_t;

  // table write request
  typedef struct packed {
    logic               we;
    logic [15:0]        idx;
    logic [ENTRY_W-1:0] entry;
  } msd_twr_t;

endpackage

@@ sv/msd_len_table.sv @@
// ----------------------------------------------------------------------------
// msd_len_table: message length table
// One write and one registered read per cycle, cleared to unknown by a
// sweep over all entries after reset.
// ----------------------------------------------------------------------------
module msd_len_table import msd_pkg::*; #(
  parameter int TABLE_DEPTH = MSD_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msd_twr_t           wr_i,
  input  logic               rd_en_i,
  input  logic [15:0]        rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  output logic               clr_busy_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               clr_busy_q, clr_busy_d;

  // clearing sweep control
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // write port: sweep first, then table loads
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.we) begin
      mem[wr_i.idx[AW-1:0]] <= wr_i.entry;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i[AW-1:0]];
    end
  end

  assign rd_data_o  = rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ sv/msd_parser.sv @@
// ----------------------------------------------------------------------------
// msd_parser: header and body parser
// Consumes one word per step, tracks header fields and body count, and
// forms the table lookup address for the word arriving next.
// ----------------------------------------------------------------------------
module msd_parser import msd_pkg::*; #(
  parameter int ID_BYTES         = MSD_ID_BYTES,
  parameter int LENGTH_BYTES     = MSD_LENGTH_BYTES,
  parameter int EXT_LENGTH_BYTES = MSD_EXT_LENGTH_BYTES,
  parameter int TABLE_DEPTH      = MSD_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enforce_i,
  input  logic               step_i,
  input  msd_in_t            item_i,
  input  logic [ENTRY_W-1:0] entry_i,
  input  logic [7:0]         next_byte_i,
  output logic [15:0]        lookup_addr_o,
  output logic               emit_o,
  output msd_out_t           res_o
);

  localparam logic [1:0]  ID_LAST  = 2'(ID_BYTES - 1);
  localparam logic [1:0]  LEN_LAST = 2'(LENGTH_BYTES - 1);
  localparam logic [1:0]  EXT_LAST = 2'(EXT_LENGTH_BYTES - 1);
  localparam logic [31:0] LEN_ONES = 32'((64'd1 << (8 * LENGTH_BYTES)) - 64'd1);
  localparam logic [31:0] EXT_ONES = 32'((64'd1 << (8 * EXT_LENGTH_BYTES)) - 64'd1);

  msd_phase_e  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] accum_q, accum_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic        halted_q, halted_d;

  logic [31:0]        acc_base, acc_new;
  logic [31:0]        nxt_base, nxt_full;
  logic [ENTRY_W-1:0] entry;
  logic               chk;
  logic [31:0]        chk_len;
  logic               emit;
  msd_kind_e          kind;
  logic [7:0]         body;
  logic [31:0]        out_len;
  logic               last;

  // header byte gathering, little endian
  assign acc_base = (cnt_q == 2'd0) ? 32'd0 : accum_q;
  assign acc_new  = acc_base | (32'(item_i.data_byte) << {cnt_q, 3'b000});
  assign entry    = ({1'b0, acc_new} < 33'(TABLE_DEPTH)) ? entry_i : '0;

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    accum_d  = accum_q;
    cur_id_d = cur_id_q;
    len_d    = len_q;
    rem_d    = rem_q;
    halted_d = halted_q;
    chk      = 1'b0;
    chk_len  = 32'd0;
    emit     = 1'b0;
    kind     = KIND_BODY;
    body     = 8'd0;
    out_len  = 32'd0;
    last     = 1'b0;
    if (step_i && (item_i.func == FUNC_DATA) && !halted_q) begin
      unique case (phase_q)
        PH_ID: begin
          if (cnt_q == ID_LAST) begin
            cnt_d    = 2'd0;
            accum_d  = 32'd0;
            cur_id_d = acc_new[15:0];
            len_d    = 32'd0;
            if (!entry[17]) begin
              halted_d = 1'b1;
              emit     = 1'b1;
              kind     = KIND_UNKNOWN;
            end else if (entry[16]) begin
              phase_d = PH_LEN;
            end else begin
              chk     = 1'b1;
              chk_len = {16'd0, entry[15:0]};
            end
          end else begin
            cnt_d   = cnt_q + 2'd1;
            accum_d = acc_new;
          end
        end
        PH_LEN: begin
          if (cnt_q == LEN_LAST) begin
            cnt_d   = 2'd0;
            accum_d = 32'd0;
            len_d   = acc_new;
            if (acc_new == LEN_ONES) begin
              phase_d = PH_EXT;
            end else begin
              chk     = 1'b1;
              chk_len = acc_new;
            end
          end else begin
            cnt_d   = cnt_q + 2'd1;
            accum_d = acc_new;
          end
        end
        PH_EXT: begin
          if (cnt_q == EXT_LAST) begin
            cnt_d   = 2'd0;
            accum_d = 32'd0;
            len_d   = acc_new;
            if (acc_new == EXT_ONES) begin
              halted_d = 1'b1;
              emit     = 1'b1;
              kind     = KIND_BADEXT;
              out_len  = acc_new;
            end else begin
              chk     = 1'b1;
              chk_len = acc_new;
            end
          end else begin
            cnt_d   = cnt_q + 2'd1;
            accum_d = acc_new;
          end
        end
        PH_BODY: begin
          rem_d   = rem_q - 32'd1;
          emit    = 1'b1;
          kind    = KIND_BODY;
          body    = item_i.data_byte;
          out_len = len_q;
          if (rem_q == 32'd1) begin
            phase_d = PH_ID;
            last    = 1'b1;
          end
        end
        default: ;
      endcase
      // length known: check it, then start body or close the message
      if (chk) begin
        len_d = chk_len;
        if (enforce_i && (chk_len > BODY_LIMIT)) begin
          halted_d = 1'b1;
          emit     = 1'b1;
          kind     = KIND_OVERSIZE;
          out_len  = chk_len;
        end else if (chk_len == 32'd0) begin
          phase_d = PH_ID;
          emit    = 1'b1;
          kind    = KIND_EMPTY;
          last    = 1'b1;
        end else begin
          rem_d   = chk_len;
          phase_d = PH_BODY;
        end
      end
    end
  end

  // lookup address for the next word, as if it completes an id
  assign nxt_base      = (cnt_d == 2'd0) ? 32'd0 : accum_d;
  assign nxt_full      = nxt_base | (32'(next_byte_i) << {cnt_d, 3'b000});
  assign lookup_addr_o = nxt_full[15:0];

  assign emit_o = emit;
  assign res_o  = '{kind: kind, message_id: cur_id_d, body_byte: body,
                    message_length: out_len, last: last};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ID;
      cnt_q    <= 2'd0;
      accum_q  <= 32'd0;
      cur_id_q <= 16'd0;
      len_q    <= 32'd0;
      rem_q    <= 32'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      accum_q  <= accum_d;
      cur_id_q <= cur_id_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      halted_q <= halted_d;
    end
  end

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped");

  // an error result always halts
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (kind == KIND_UNKNOWN || kind == KIND_OVERSIZE || kind == KIND_BADEXT))
    |=> halted_q)
    else $error("error word without halt");

  // last body word returns to id parsing
  a_last_to_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && kind == KIND_BODY && last) |=> (phase_q == PH_ID))
    else $error("message end without return to id phase");

  // body phase always has bytes left
  a_body_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (rem_q != 32'd0))
    else $error("body phase with no bytes remaining");

endmodule

@@ sv/message_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// message_stream_deframer: length-prefixed message deframer
// Byte-serial header parse with table lookup, body words tagged with id.
// ----------------------------------------------------------------------------
// An accepted word is held in the input register, its result in the result register.
// Throughput: 1 word per cycle unless the output stalls or the table clears,
// set by the single parser stage and the registered read of the length table.
// Reset: all control state clears; the table then runs a clearing sweep over
// all TABLE_DEPTH entries (1024 by default) with in_stall_o high; config writes
// are taken throughout.
module message_stream_deframer import msd_pkg::*; #(
  parameter int ID_BYTES         = MSD_ID_BYTES,
  parameter int LENGTH_BYTES     = MSD_LENGTH_BYTES,
  parameter int EXT_LENGTH_BYTES = MSD_EXT_LENGTH_BYTES,
  parameter int TABLE_DEPTH      = MSD_TABLE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  msd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output msd_out_t out_data_o
);

  logic               enforce_q;
  logic               s1_valid_q, s1_valid_d;
  msd_in_t            s1_q;
  logic               out_valid_q;
  msd_out_t           out_q;
  logic               move, step, accept, clr_busy;
  msd_twr_t           twr;
  logic [ENTRY_W-1:0] entry;
  logic [15:0]        lookup_addr;
  logic               emit;
  msd_out_t           res;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enforce_q <= 1'b1;
    end else if (cfg_we_i) begin
      enforce_q <= cfg_wdata_i;
    end
  end

  // handshake
  assign move       = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && move;
  assign in_stall_o = clr_busy || (s1_valid_q && !move);
  assign accept     = in_valid_i && !in_stall_o;

  // table load goes in at acceptance, ahead of any later lookup
  assign twr = '{we: accept && (in_data_i.func == FUNC_TABLE) &&
                     ({7'd0, in_data_i.table_index} < 17'(TABLE_DEPTH)),
                 idx: 16'(in_data_i.table_index),
                 entry: {in_data_i.entry_known, in_data_i.entry_variable,
                         in_data_i.entry_length}};

  msd_len_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (twr),
    .rd_en_i    (accept),
    .rd_addr_i  (lookup_addr),
    .rd_data_o  (entry),
    .clr_busy_o (clr_busy)
  );

  // input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  msd_parser #(
    .ID_BYTES         (ID_BYTES),
    .LENGTH_BYTES     (LENGTH_BYTES),
    .EXT_LENGTH_BYTES (EXT_LENGTH_BYTES),
    .TABLE_DEPTH      (TABLE_DEPTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enforce_i     (enforce_q),
    .step_i        (step),
    .item_i        (s1_q),
    .entry_i       (entry),
    .next_byte_i   (in_data_i.data_byte),
    .lookup_addr_o (lookup_addr),
    .emit_o        (emit),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/tb_message_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_message_stream_deframer: self-checking bench for the stream deframer
// A short table of directed words comes first, then random message streams
// under both limit settings, and one protocol fault at the end, since a
// fault halts the block until reset. Every output word is checked against
// an in-bench model of the deframer or an expected word typed into the table.
// ----------------------------------------------------------------------------
module tb_message_stream_deframer import msd_pkg::*;;

  typedef enum logic [1:0] {
    CHECK_MODEL,  // expected output comes from the bench model
    CHECK_NONE,   // no output word is caused
    CHECK_TYPED   // expected output is written into the table
  } check_mode_e;

  typedef struct {
    check_mode_e mode;
    msd_in_t     word;
    msd_out_t    want;
  } opening_row_t;

  localparam logic [31:0] LEN_ESCAPE = 32'((64'd1 << (8 * MSD_LENGTH_BYTES)) - 64'd1);
  localparam logic [31:0] EXT_BAD    = 32'((64'd1 << (8 * MSD_EXT_LENGTH_BYTES)) - 64'd1);

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_stall_o;
  msd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  msd_out_t out_data_o;

  // deframer model state
  msd_phase_e         ps_phase;
  int unsigned        ps_count;
  logic [31:0]        ps_accum;
  logic [15:0]        ps_id;
  logic [31:0]        ps_len;
  logic [31:0]        ps_left;
  bit                 ps_halted;
  bit                 ps_limit;
  logic [ENTRY_W-1:0] ps_table [MSD_TABLE_DEPTH];

  // output words still owed by the block, oldest first
  msd_out_t     deframed_words_q [$];
  opening_row_t opening_rows [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  words_sent;
  bit           tx_calm;
  bit           id_usable [MSD_TABLE_DEPTH];

  message_stream_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic msd_out_t out_word(input msd_kind_e kind, input logic [15:0] id,
                                        input logic [7:0] b, input logic [31:0] len,
                                        input logic last);
    msd_out_t r;
    r.kind           = kind;
    r.message_id     = id;
    r.body_byte      = b;
    r.message_length = len;
    r.last           = last;
    return r;
  endfunction

  // data word with noise in the fields the block ignores
  function automatic msd_in_t data_word(input logic [7:0] b);
    msd_in_t w;
    w.func           = FUNC_DATA;
    w.data_byte      = b;
    w.table_index    = 10'($urandom);
    w.entry_known    = 1'($urandom);
    w.entry_variable = 1'($urandom);
    w.entry_length   = 16'($urandom);
    return w;
  endfunction

  function automatic msd_in_t table_word(input logic [9:0] idx, input logic known,
                                         input logic variable, input logic [15:0] len);
    msd_in_t w;
    w.func           = FUNC_TABLE;
    w.data_byte      = 8'($urandom);
    w.table_index    = idx;
    w.entry_known    = known;
    w.entry_variable = variable;
    w.entry_length   = len;
    return w;
  endfunction

  function automatic int unsigned idle_span();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
  endfunction

  // append one expected output word
  function automatic void owe_word(input msd_out_t w);
    deframed_words_q.insert(deframed_words_q.size(), w);
  endfunction

  // append one directed row
  function automatic void add_row(input check_mode_e mode, input msd_in_t word,
                                  input msd_out_t want);
    opening_rows.insert(opening_rows.size(), opening_row_t'{mode, word, want});
  endfunction

  // header byte collection, little endian
  function automatic bit shift_in(input logic [7:0] b, input int unsigned nbytes,
                                  output logic [31:0] val);
    ps_accum = ps_accum | (32'(b) << (8 * ps_count));
    ps_count = ps_count + 1;
    val      = ps_accum;
    if (ps_count != nbytes) return 1'b0;
    ps_count = 0;
    ps_accum = '0;
    return 1'b1;
  endfunction

  // length settled: limit check, then empty message or body
  function automatic bit length_known(output msd_out_t r);
    r = '0;
    if (ps_limit && ps_len > BODY_LIMIT) begin
      ps_halted = 1'b1;
      r = out_word(KIND_OVERSIZE, ps_id, 8'h00, ps_len, 1'b0);
      return 1'b1;
    end
    if (ps_len == 32'd0) begin
      ps_phase = PH_ID;
      r = out_word(KIND_EMPTY, ps_id, 8'h00, 32'd0, 1'b1);
      return 1'b1;
    end
    ps_left  = ps_len;
    ps_phase = PH_BODY;
    return 1'b0;
  endfunction

  // one accepted input word through the deframer; returns 1 with an output
  function automatic bit deframe_step(input msd_in_t w, output msd_out_t r);
    logic [31:0]        val;
    logic [ENTRY_W-1:0] ent;
    r = '0;
    if (w.func == FUNC_TABLE) begin
      ps_table[w.table_index] = {w.entry_known, w.entry_variable, w.entry_length};
      return 1'b0;
    end
    if (ps_halted) return 1'b0;
    case (ps_phase)
      PH_ID: begin
        if (!shift_in(w.data_byte, MSD_ID_BYTES, val)) return 1'b0;
        ps_id  = val[15:0];
        ps_len = '0;
        ent    = (val < MSD_TABLE_DEPTH) ? ps_table[val[9:0]] : '0;
        if (!ent[17]) begin
          ps_halted = 1'b1;
          r = out_word(KIND_UNKNOWN, ps_id, 8'h00, 32'd0, 1'b0);
          return 1'b1;
        end
        if (ent[16]) begin
          ps_phase = PH_LEN;
          return 1'b0;
        end
        ps_len = {16'd0, ent[15:0]};
        return length_known(r);
      end
      PH_LEN: begin
        if (!shift_in(w.data_byte, MSD_LENGTH_BYTES, val)) return 1'b0;
        ps_len = val;
        if (val == LEN_ESCAPE) begin
          ps_phase = PH_EXT;
          return 1'b0;
        end
        return length_known(r);
      end
      PH_EXT: begin
        if (!shift_in(w.data_byte, MSD_EXT_LENGTH_BYTES, val)) return 1'b0;
        ps_len = val;
        if (val == EXT_BAD) begin
          ps_halted = 1'b1;
          r = out_word(KIND_BADEXT, ps_id, 8'h00, val, 1'b0);
          return 1'b1;
        end
        return length_known(r);
      end
      default: begin
        ps_left = ps_left - 32'd1;
        r = out_word(KIND_BODY, ps_id, w.data_byte, ps_len, ps_left == 32'd0);
        if (ps_left == 32'd0) ps_phase = PH_ID;
        return 1'b1;
      end
    endcase
  endfunction

  // offer one word, wait for acceptance, then record what it should cause
  task automatic send_word(input msd_in_t w, input check_mode_e mode, input msd_out_t typed);
    int unsigned gap;
    bit          has;
    msd_out_t    pred;
    gap = 0;
    if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
    if (!tx_calm && $urandom_range(0, 3) == 0) gap = idle_span();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent = words_sent + 1;
    has = deframe_step(w, pred);
    case (mode)
      CHECK_MODEL: if (has) owe_word(pred);
      CHECK_TYPED: owe_word(typed);
      default: ;
    endcase
  endtask

  task automatic load_entry(input logic [9:0] idx, input logic known, input logic variable,
                            input logic [15:0] len);
    send_word(table_word(idx, known, variable, len), CHECK_MODEL, '0);
    id_usable[idx] = known && (variable || len <= 16'd64);
  endtask

  // table rewrite that keeps every usable id usable
  task automatic random_entry();
    logic [9:0] idx;
    idx = 10'($urandom);
    case ($urandom_range(0, 2))
      0: load_entry(idx, 1'b1, 1'b0, 16'($urandom_range(0, 24)));
      1: load_entry(idx, 1'b1, 1'b1, 16'($urandom));
      default: begin
        if (id_usable[idx]) load_entry(idx, 1'b1, 1'b0, 16'($urandom_range(0, 24)));
        else load_entry(idx, 1'b0, 1'($urandom), 16'($urandom));
      end
    endcase
  endtask

  // little-endian field, optionally with table writes slipped in between bytes
  task automatic send_le(input logic [31:0] v, input int unsigned nbytes, input bit mix);
    for (int i = 0; i < nbytes; i++) begin
      if (mix && $urandom_range(0, 15) == 0) random_entry();
      send_word(data_word(v[8*i +: 8]), CHECK_MODEL, '0);
    end
  endtask

  task automatic finish_body();
    while (ps_phase == PH_BODY && !ps_halted) send_le(32'($urandom), 1, 1'b1);
  endtask

  task automatic random_message();
    logic [9:0]  id;
    int unsigned pick;
    do id = 10'($urandom); while (!id_usable[id]);
    send_le({22'd0, id}, MSD_ID_BYTES, 1'b1);
    if (ps_phase == PH_LEN) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_le(32'd0, MSD_LENGTH_BYTES, 1'b1);
      end else if (pick < 22) begin
        send_le(LEN_ESCAPE, MSD_LENGTH_BYTES, 1'b1);
        send_le((pick < 14) ? 32'd0 : $urandom_range(1, 24), MSD_EXT_LENGTH_BYTES, 1'b1);
      end else begin
        send_le($urandom_range(1, 24), MSD_LENGTH_BYTES, 1'b1);
      end
    end
    finish_body();
  endtask

  task automatic random_messages(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) random_message();
  endtask

  // wait until the block has nothing left to say
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (deframed_words_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic on);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ps_limit    = on;
  endtask

  // one protocol fault halts the block for good, so it closes the run
  task automatic close_with_fault();
    logic [9:0]  idx;
    logic [31:0] ext;
    int unsigned pick;
    msd_in_t     w;
    pick = $urandom_range(0, 2);
    set_limit((pick == 1) ? 1'b1 : 1'($urandom));
    if (pick == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        do idx = 10'($urandom); while (id_usable[idx]);
        load_entry(idx, 1'b0, 1'($urandom), 16'($urandom));
        send_le({22'd0, idx}, MSD_ID_BYTES, 1'b0);
      end else begin
        // id past the end of the table
        send_le({16'd0, 8'($urandom_range(4, 255)), 8'($urandom)}, MSD_ID_BYTES, 1'b0);
      end
    end else begin
      ext = EXT_BAD;
      if (pick == 1) begin
        ext = $urandom;
        if (ext <= BODY_LIMIT) ext[16] = 1'b1;
        if (ext == EXT_BAD) ext[0] = 1'b0;
      end
      idx = 10'($urandom);
      load_entry(idx, 1'b1, 1'b1, 16'($urandom));
      send_le({22'd0, idx}, MSD_ID_BYTES, 1'b0);
      send_le(LEN_ESCAPE, MSD_LENGTH_BYTES, 1'b0);
      send_le(ext, MSD_EXT_LENGTH_BYTES, 1'b0);
    end
    // halted: data is dropped, table writes still land
    repeat (24) begin
      w = data_word(8'($urandom));
      w.func = 1'($urandom);
      send_word(w, CHECK_MODEL, '0);
    end
  endtask

  // output checking
  always @(posedge clk_i) begin : result_check
    msd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_words_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word at %0t: kind=%0d id=%h byte=%h len=%h last=%b", $time,
                   out_data_o.kind, out_data_o.message_id, out_data_o.body_byte,
                   out_data_o.message_length, out_data_o.last);
        mismatches = mismatches + 1;
      end else begin
        want = deframed_words_q.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.message_id !== want.message_id ||
            out_data_o.body_byte !== want.body_byte ||
            out_data_o.message_length !== want.message_length ||
            out_data_o.last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch at %0t: got %0d/%h/%h/%h/%b want %0d/%h/%h/%h/%b", $time,
                     out_data_o.kind, out_data_o.message_id, out_data_o.body_byte,
                     out_data_o.message_length, out_data_o.last, want.kind,
                     want.message_id, want.body_byte, want.message_length, want.last);
          mismatches = mismatches + 1;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // output stall: random gaps, calm stretches, two long hold-offs
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned next_hold;
    bit          calm;
    stall_left = 0;
    hold_left  = 0;
    next_hold  = 100;
    calm       = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (results_seen >= next_hold) begin
        hold_left = 150;
        next_hold = (next_hold == 100) ? 600 : 32'hFFFF_FFFF;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left  = idle_span() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    results_seen = 0;
    words_sent  = 0;
    tx_calm     = 1'b0;
    ps_phase    = PH_ID;
    ps_count    = 0;
    ps_accum    = '0;
    ps_id       = '0;
    ps_len      = '0;
    ps_left     = '0;
    ps_halted   = 1'b0;
    ps_limit    = 1'b1;
    foreach (ps_table[i]) ps_table[i] = '0;
    foreach (id_usable[i]) id_usable[i] = 1'b0;

    // directed words, limit at its reset value
    add_row(CHECK_NONE, table_word(10'h000, 1'b1, 1'b0, 16'h0000), '0);
    add_row(CHECK_NONE, table_word(10'h3FF, 1'b1, 1'b1, 16'hFFFF), '0);
    add_row(CHECK_NONE, table_word(10'h155, 1'b1, 1'b1, 16'h5555), '0);
    // id zero, fixed empty body
    add_row(CHECK_NONE, data_word(8'h00), '0);
    add_row(CHECK_TYPED, data_word(8'h00),
            out_word(KIND_EMPTY, 16'h0000, 8'h00, 32'd0, 1'b1));
    // top id, variable length 2
    add_row(CHECK_NONE, data_word(8'hFF), '0);
    add_row(CHECK_NONE, data_word(8'h03), '0);
    add_row(CHECK_NONE, data_word(8'h02), '0);
    add_row(CHECK_NONE, data_word(8'h00), '0);
    add_row(CHECK_TYPED, data_word(8'hFF),
            out_word(KIND_BODY, 16'h03FF, 8'hFF, 32'd2, 1'b0));
    // rewrite of the live entry must not disturb the body
    add_row(CHECK_NONE, table_word(10'h3FF, 1'b1, 1'b0, 16'h0001), '0);
    add_row(CHECK_TYPED, data_word(8'h00),
            out_word(KIND_BODY, 16'h03FF, 8'h00, 32'd2, 1'b1));
    // same id now fixed length 1
    add_row(CHECK_NONE, data_word(8'hFF), '0);
    add_row(CHECK_NONE, data_word(8'h03), '0);
    add_row(CHECK_MODEL, data_word(8'hA5), '0);
    // escape to extended length 1
    add_row(CHECK_NONE, data_word(8'h55), '0);
    add_row(CHECK_NONE, data_word(8'h01), '0);
    add_row(CHECK_NONE, data_word(8'hFF), '0);
    add_row(CHECK_NONE, data_word(8'hFF), '0);
    add_row(CHECK_NONE, data_word(8'h01), '0);
    add_row(CHECK_NONE, data_word(8'h00), '0);
    add_row(CHECK_NONE, data_word(8'h00), '0);
    add_row(CHECK_NONE, data_word(8'h00), '0);
    add_row(CHECK_MODEL, data_word(8'h5A), '0);
    add_row(CHECK_NONE, table_word(10'h2AA, 1'b0, 1'b0, 16'hAAAA), '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i])
      send_word(opening_rows[i].word, opening_rows[i].mode, opening_rows[i].want);

    // random streams, limit off
    set_limit(1'b0);
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) load_entry(10'($urandom), 1'b1, 1'b1, 16'($urandom));
      else load_entry(10'($urandom), 1'b1, 1'b0, 16'($urandom_range(0, 24)));
    end
    random_messages(250);

    // limit on
    set_limit(1'b1);
    random_messages(250);

    set_limit(1'b0);
    random_messages(150);

    close_with_fault();

    // drain and settle
    in_valid_i <= 1'b0;
    while (deframed_words_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/msd_pkg.sv
sv/msd_len_table.sv
sv/msd_parser.sv
sv/message_stream_deframer.sv
sim/tb_message_stream_deframer.sv
